@@ rtl/core/chs_pkg.sv @@
`timescale 1ns / 1ps

package chs_pkg;

    // Field widths of the request, response and configuration
    localparam int MODE_W    = 2;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 11;
    localparam int CFG_W     = 9;

    // Default sizes and reset values
    localparam int MAX_BUCKETS_DEF = 256;
    localparam int NODE_COUNT_DEF  = 1024;
    localparam logic [CFG_W-1:0] BUCKET_CNT_RST = 9'd16;

    // Dividend bits consumed per cycle by the modulo unit
    localparam int DIV_BITS = 4;

    // Operation codes; code three behaves as a query
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    // Status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic               was_present;
        logic               changed;
        logic               status;
        logic [COUNT_W-1:0] member_count;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_NODE,
        S_DECIDE,
        S_ALLOC,
        S_FREE,
        S_RESP
    } t_state;

endpackage

@@ rtl/core/chs_req_if.sv @@
`timescale 1ns / 1ps

interface chs_req_if;
    logic          valid;
    logic          ready;
    chs_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/chs_rsp_if.sv @@
`timescale 1ns / 1ps

interface chs_rsp_if;
    logic          valid;
    logic          ready;
    chs_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/chs_mod.sv @@
`timescale 1ns / 1ps

// Unsigned 32-bit modulo by a small divisor, DIV_BITS quotient bits per cycle
module chs_mod #(
    parameter int MW = 9
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [chs_pkg::VALUE_W-1:0]  i_dividend,
    input  logic [MW-1:0]                i_divisor,
    output logic                         o_done,
    output logic [MW-1:0]                o_rem
);

    localparam int STEPS = chs_pkg::VALUE_W / chs_pkg::DIV_BITS;
    localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic                         r_busy;
    logic                         r_done;
    logic [CW-1:0]                r_cnt;
    logic [chs_pkg::VALUE_W-1:0]  r_q;
    logic [MW-1:0]                r_rem;
    logic [MW-1:0]                r_div;
    logic [chs_pkg::VALUE_W-1:0]  n_q;
    logic [MW-1:0]                n_rem;

    // Restoring remainder steps, MSB first
    always_comb begin
        logic [MW:0] t;
        n_q   = r_q;
        n_rem = r_rem;
        t     = '0;
        for (int k = 0; k < chs_pkg::DIV_BITS; k++) begin
            t   = {n_rem, n_q[chs_pkg::VALUE_W-1]};
            n_q = n_q << 1;
            if (t >= {1'b0, r_div}) begin
                t = t - {1'b0, r_div};
            end
            n_rem = t[MW-1:0];
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ rtl/core/chained_hash_set.sv @@
// Hash set of signed 32-bit values, chained buckets over a fixed node pool.
// Request channel i_req (valid/ready): mode (add, remove, query) and value.
// Response channel o_rsp (valid/ready): was_present, changed, status
// (pool full on a refused add) and member_count after the operation.
// Config: i_cfg_we/i_cfg_wdata write the bucket count (0 acts as 1, values
// above MAX_BUCKETS saturate); write it only while no request is in flight.
// One request at a time: ready is high only when the sequencer is idle.
// Per request the sequencer steps through: accept, the bucket modulo (4 bits per
// cycle), head read, one node state per chain node visited, decide (which also
// unlinks on a remove), then an insert or a free-list return, and finally the
// load of the response register, which waits while an earlier response stalls.
// The sequencer goes back to idle after each response and only there accepts
// the next request, so a new request is never taken before the last is done.
// The response register frees the sequencer; a stalled receiver only holds
// the next request once that one is finished.
// Reset (synchronous) empties every bucket, puts all nodes on the free list,
// clears the count and sets the bucket count to 16; no clearing pass is needed.
`timescale 1ns / 1ps

module chained_hash_set #(
    parameter int MAX_BUCKETS = chs_pkg::MAX_BUCKETS_DEF,
    parameter int NODE_COUNT  = chs_pkg::NODE_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [chs_pkg::CFG_W-1:0]  i_cfg_wdata,
    chs_req_if.sink                    i_req,
    chs_rsp_if.source                  o_rsp
);

    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int MW = $clog2(MAX_BUCKETS + 1);
    localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int LW = $clog2(NODE_COUNT + 1);
    localparam logic [LW-1:0] NIL = LW'(NODE_COUNT);

    chs_pkg::t_state r_state, n_state;

    logic [chs_pkg::CFG_W-1:0]        r_bucket_cnt;
    logic [chs_pkg::MODE_W-1:0]       r_mode, n_mode;
    logic [chs_pkg::VALUE_W-1:0]      r_value, n_value;
    logic [BW-1:0]                    r_bucket, n_bucket;
    logic [LW-1:0]                    r_head, n_head;
    logic [LW-1:0]                    r_cur, n_cur;
    logic [LW-1:0]                    r_prev, n_prev;
    logic [LW-1:0]                    r_nxt, n_nxt;
    logic [LW-1:0]                    r_steps, n_steps;
    logic                             r_found, n_found;
    logic                             r_changed, n_changed;
    logic                             r_full, n_full;
    logic [LW-1:0]                    r_free_head, n_free_head;
    logic [LW-1:0]                    r_fill, n_fill;
    logic [LW-1:0]                    r_count, n_count;
    logic                             r_out_valid, n_out_valid;
    chs_pkg::t_rsp                    r_out, n_out;

    // Memories
    logic [chs_pkg::VALUE_W-1:0]      m_vals  [NODE_COUNT];
    logic [LW-1:0]                    m_links [NODE_COUNT];
    logic [LW-1:0]                    m_heads [MAX_BUCKETS];
    logic [MAX_BUCKETS-1:0]           r_head_vld;

    // Read and write ports
    logic [LW-1:0]                    rd_node;
    logic [chs_pkg::VALUE_W-1:0]      r_val_rd;
    logic [LW-1:0]                    r_link_rd;
    logic [LW-1:0]                    r_rd_node;
    logic                             r_rd_fresh;
    logic [LW-1:0]                    link_q;
    logic [LW-1:0]                    r_head_rd;
    logic                             r_head_rd_vld;
    logic                             vals_we;
    logic                             links_we;
    logic [LW-1:0]                    links_waddr;
    logic [LW-1:0]                    links_wdata;
    logic                             heads_we;
    logic [BW-1:0]                    heads_waddr;
    logic [LW-1:0]                    heads_wdata;

    // Modulo unit
    logic                             div_start;
    logic                             div_done;
    logic [MW-1:0]                    div_rem;
    logic [31:0]                      m_eff;
    logic [chs_pkg::VALUE_W-1:0]      v_u;
    logic [chs_pkg::VALUE_W-1:0]      v_mag;
    logic [LW-1:0]                    steps_inc;

    // Effective modulus: zero acts as one, large values saturate
    always_comb begin
        m_eff = {23'd0, r_bucket_cnt};
        if (m_eff == 32'd0) begin
            m_eff = 32'd1;
        end else if (m_eff > 32'(MAX_BUCKETS)) begin
            m_eff = 32'(MAX_BUCKETS);
        end
    end

    // Magnitude of the incoming value, -2^31 maps to 2^31
    assign v_u   = $unsigned(i_req.data.value);
    assign v_mag = v_u[chs_pkg::VALUE_W-1] ? (32'd0 - v_u) : v_u;

    chs_mod #(
        .MW (MW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (v_mag),
        .i_divisor  (MW'(m_eff)),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // Nodes at or above the fill mark were never written and link to the next node
    assign link_q    = r_rd_fresh ? (r_rd_node + 1'b1) : r_link_rd;
    assign steps_inc = r_steps + 1'b1;

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_cnt <= chs_pkg::BUCKET_CNT_RST;
        end else if (i_cfg_we) begin
            r_bucket_cnt <= i_cfg_wdata;
        end
    end

    // Node memories: one read and one write address each
    always_ff @(posedge i_clk) begin
        r_val_rd   <= m_vals[rd_node[NW-1:0]];
        r_link_rd  <= m_links[rd_node[NW-1:0]];
        r_rd_node  <= rd_node;
        r_rd_fresh <= (rd_node >= r_fill);
        if (vals_we) begin
            m_vals[r_free_head[NW-1:0]] <= r_value;
        end
        if (links_we) begin
            m_links[links_waddr[NW-1:0]] <= links_wdata;
        end
    end

    // Bucket head memory, read at the modulo result
    always_ff @(posedge i_clk) begin
        r_head_rd <= m_heads[BW'(div_rem)];
        if (heads_we) begin
            m_heads[heads_waddr] <= heads_wdata;
        end
    end

    // Head valid bits: an unwritten bucket reads as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld    <= '0;
            r_head_rd_vld <= 1'b0;
        end else begin
            r_head_rd_vld <= r_head_vld[BW'(div_rem)];
            if (heads_we) begin
                r_head_vld[heads_waddr] <= 1'b1;
            end
        end
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= chs_pkg::S_IDLE;
            r_free_head <= '0;
            r_fill      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_fill      <= n_fill;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers of the current request
    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_value   <= n_value;
        r_bucket  <= n_bucket;
        r_head    <= n_head;
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_nxt     <= n_nxt;
        r_steps   <= n_steps;
        r_found   <= n_found;
        r_changed <= n_changed;
        r_full    <= n_full;
        r_out     <= n_out;
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_value     = r_value;
        n_bucket    = r_bucket;
        n_head      = r_head;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_nxt       = r_nxt;
        n_steps     = r_steps;
        n_found     = r_found;
        n_changed   = r_changed;
        n_full      = r_full;
        n_free_head = r_free_head;
        n_fill      = r_fill;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid & ~o_rsp.ready;
        rd_node     = r_cur;
        vals_we     = 1'b0;
        links_we    = 1'b0;
        links_waddr = r_cur;
        links_wdata = r_free_head;
        heads_we    = 1'b0;
        heads_waddr = r_bucket;
        heads_wdata = r_nxt;
        div_start   = 1'b0;
        i_req.ready = 1'b0;

        unique case (r_state)
            chs_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_mode    = i_req.data.mode;
                    n_value   = v_u;
                    n_found   = 1'b0;
                    n_changed = 1'b0;
                    n_full    = 1'b0;
                    div_start = 1'b1;
                    n_state   = chs_pkg::S_HASH;
                end
            end
            chs_pkg::S_HASH: begin
                if (div_done) begin
                    n_bucket = BW'(div_rem);
                    n_state  = chs_pkg::S_HEAD;
                end
            end
            chs_pkg::S_HEAD: begin
                n_head  = r_head_rd_vld ? r_head_rd : NIL;
                n_cur   = n_head;
                n_prev  = NIL;
                n_steps = '0;
                rd_node = n_head;
                n_state = (n_head >= NIL) ? chs_pkg::S_DECIDE : chs_pkg::S_NODE;
            end
            chs_pkg::S_NODE: begin
                // Node data of r_cur is in the read registers
                if (r_val_rd == r_value) begin
                    n_found = 1'b1;
                    n_nxt   = link_q;
                    n_state = chs_pkg::S_DECIDE;
                end else begin
                    n_prev  = r_cur;
                    n_cur   = link_q;
                    n_steps = steps_inc;
                    rd_node = link_q;
                    if (link_q >= NIL || steps_inc == NIL) begin
                        n_state = chs_pkg::S_DECIDE;
                    end
                end
            end
            chs_pkg::S_DECIDE: begin
                priority if (r_mode == chs_pkg::MODE_ADD && !r_found) begin
                    if (r_free_head >= NIL) begin
                        n_full  = 1'b1;
                        n_state = chs_pkg::S_RESP;
                    end else begin
                        rd_node = r_free_head;
                        n_state = chs_pkg::S_ALLOC;
                    end
                end else if (r_mode == chs_pkg::MODE_REMOVE && r_found) begin
                    // Unlink: predecessor or bucket head skips the node
                    if (r_prev >= NIL) begin
                        heads_we    = 1'b1;
                        heads_wdata = r_nxt;
                    end else begin
                        links_we    = 1'b1;
                        links_waddr = r_prev;
                        links_wdata = r_nxt;
                    end
                    n_changed = 1'b1;
                    n_state   = chs_pkg::S_FREE;
                end else begin
                    n_state = chs_pkg::S_RESP;
                end
            end
            chs_pkg::S_ALLOC: begin
                // New node goes in at the head of its bucket chain
                vals_we     = 1'b1;
                links_we    = 1'b1;
                links_waddr = r_free_head;
                links_wdata = r_head;
                heads_we    = 1'b1;
                heads_wdata = r_free_head;
                n_free_head = link_q;
                n_count     = r_count + 1'b1;
                if (r_free_head == r_fill) begin
                    n_fill = r_fill + 1'b1;
                end
                n_changed = 1'b1;
                n_state   = chs_pkg::S_RESP;
            end
            chs_pkg::S_FREE: begin
                // Removed node returns to the head of the free list
                links_we    = 1'b1;
                links_waddr = r_cur;
                links_wdata = r_free_head;
                n_free_head = r_cur;
                if (r_count != '0) begin
                    n_count = r_count - 1'b1;
                end
                n_state = chs_pkg::S_RESP;
            end
            chs_pkg::S_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out.was_present  = r_found;
                    n_out.changed      = r_changed;
                    n_out.status       = r_full ? chs_pkg::STATUS_FULL : chs_pkg::STATUS_OK;
                    n_out.member_count = chs_pkg::COUNT_W'(r_count);
                    n_out_valid        = 1'b1;
                    n_state            = chs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = chs_pkg::S_IDLE;
            end
        endcase
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

`ifndef ASSERT_OFF
    // A new response is only loaded from the response state
    a_rsp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(r_state) == chs_pkg::S_RESP)
        else $error("response loaded outside the response state");

    // An empty free list means every node has been handed out at least once
    a_pool_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free_head >= NIL) |-> (r_fill == NIL))
        else $error("free list empty while fresh nodes remain");

    // Members never outnumber the nodes ever allocated
    a_count_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_fill)
        else $error("member count above allocated nodes");

    // The modulo unit only finishes while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == chs_pkg::S_HASH)
        else $error("modulo result outside the hash state");
`endif

endmodule
